// ----- rtl/core/mgnu_pkg.sv -----
// Shared types, constants and helpers for the grid node update block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package mgnu_pkg;

  localparam int CELL_W     = 6;
  localparam int DATA_W     = 32;
  localparam int GS_W       = 16;
  localparam int POS_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STAGES = 32;
  // input register, one stage per quotient bit, saturation register
  localparam int DIV_LAT    = DIV_STAGES + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY = 3'd0,
    CFG_CX      = 3'd1,
    CFG_CY      = 3'd2,
    CFG_CZ      = 3'd3,
    CFG_VX      = 3'd4,
    CFG_VZ      = 3'd5,
    CFG_HXZ     = 3'd6,
    CFG_HY      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic [CELL_W-1:0]        cell_x;
    logic [CELL_W-1:0]        cell_y;
    logic [CELL_W-1:0]        cell_z;
    logic signed [DATA_W-1:0] momentum_x;
    logic signed [DATA_W-1:0] momentum_y;
    logic signed [DATA_W-1:0] momentum_z;
    logic [DATA_W-1:0]        node_mass;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
    logic signed [DATA_W-1:0] velocity_z;
    logic                     node_active;
    logic                     hit_obstacle;
  } out_t;

  typedef struct packed {
    logic [GS_W-1:0]          gravity_step;
    logic [POS_W-1:0]         center_x;
    logic [POS_W-1:0]         center_y;
    logic [POS_W-1:0]         center_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_z;
    logic [POS_W-1:0]         half_xz;
    logic [POS_W-1:0]         half_y;
  } cfg_t;

  // classified request, front to back
  typedef struct packed {
    in_t        node;
    logic [2:0] wall_lo;
    logic [2:0] wall_hi;
    logic       in_obst;
    axis_e      axis;
    logic       positive;
  } item_t;

  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/mgnu_front.sv -----
// Front end: accepts requests and classifies walls and obstacle face.
// Depends on mgnu_pkg.
`timescale 1ns / 1ps
module mgnu_front #(
  parameter int GRID_SIZE  = 64,
  parameter int WALL_CELLS = 2,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  mgnu_pkg::in_t item_i,
  input  mgnu_pkg::cfg_t cfg_i,
  input  logic          ready_i,
  output logic          busy,
  output logic          push_o,
  output mgnu_pkg::item_t item_o
);
  import mgnu_pkg::*;

  localparam int PW = CELL_W + FRAC_BITS;
  localparam int GW = ((PW > POS_W + 1) ? PW : POS_W + 1) + 2;

  logic  valid_q, valid_d, accept;
  item_t item_q, item_d;

  logic signed [GW-1:0] pos [3];
  logic signed [GW-1:0] lo  [3];
  logic signed [GW-1:0] hi  [3];
  logic [CELL_W-1:0]    cidx [3];
  logic [POS_W-1:0]     cen  [3];
  logic [POS_W-1:0]     hlf  [3];

  assign busy   = valid_q && !ready_i;
  assign accept = start && !busy;
  assign valid_d = busy ? 1'b1 : accept;
  assign push_o = valid_q && ready_i;
  assign item_o = item_q;

  assign cidx[0] = item_i.cell_x;
  assign cidx[1] = item_i.cell_y;
  assign cidx[2] = item_i.cell_z;
  assign cen[0]  = cfg_i.center_x;
  assign cen[1]  = cfg_i.center_y;
  assign cen[2]  = cfg_i.center_z;
  assign hlf[0]  = cfg_i.half_xz;
  assign hlf[1]  = cfg_i.half_y;
  assign hlf[2]  = cfg_i.half_xz;

  always_comb begin
    logic signed [GW-1:0] best, dlo, dhi, c, h;
    logic in_box;
    item_d       = '0;
    item_d.node  = item_i;
    item_d.axis  = AXIS_X;
    in_box       = 1'b1;
    for (int a = 0; a < 3; a++) begin
      pos[a] = signed'({{(GW-PW){1'b0}}, cidx[a], {FRAC_BITS{1'b0}}});
      c      = signed'({{(GW-POS_W){1'b0}}, cen[a]});
      h      = signed'({{(GW-POS_W){1'b0}}, hlf[a]});
      lo[a]  = c - h;
      hi[a]  = c + h;
      if (!(pos[a] > lo[a] && pos[a] < hi[a])) in_box = 1'b0;
      item_d.wall_lo[a] = int'(cidx[a]) < WALL_CELLS;
      item_d.wall_hi[a] = int'(cidx[a]) > GRID_SIZE - WALL_CELLS;
    end
    item_d.in_obst = in_box;
    // nearest face, earlier face wins ties
    best = pos[0] - lo[0];
    for (int a = 0; a < 3; a++) begin
      dlo = pos[a] - lo[a];
      dhi = hi[a] - pos[a];
      if (a > 0 && dlo < best) begin
        best = dlo;
        item_d.axis = axis_e'(2'(a));
        item_d.positive = 1'b0;
      end
      if (dhi < best) begin
        best = dhi;
        item_d.axis = axis_e'(2'(a));
        item_d.positive = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- rtl/core/mgnu_fifo.sv -----
// Short request queue between front and back.
// Depends on mgnu_pkg for the item type.
`timescale 1ns / 1ps
module mgnu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mgnu_pkg::item_t data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mgnu_pkg::item_t data_o
);
  import mgnu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign ready_o = cnt_q != CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/mgnu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Computes (|num| << FRAC_BITS) / den with sign; depends on mgnu_pkg.
`timescale 1ns / 1ps
module mgnu_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic signed [mgnu_pkg::DATA_W-1:0] num_i,
  input  logic [mgnu_pkg::DATA_W-1:0]        den_i,
  output logic signed [mgnu_pkg::DATA_W-1:0] quot_o
);
  import mgnu_pkg::*;

  logic [DATA_W-1:0] rem_q [DIV_STAGES+1];
  logic [DATA_W-1:0] low_q [DIV_STAGES+1];
  logic [DATA_W-1:0] quo_q [DIV_STAGES+1];
  logic [DATA_W-1:0] den_q [DIV_STAGES+1];
  logic              neg_q [DIV_STAGES+1];
  logic              ovf_q [DIV_STAGES+1];
  logic signed [DATA_W-1:0] quot_q;

  logic [DATA_W-1:0] mag, top;
  logic [DATA_W-1:0] q_end;

  assign mag = num_i[DATA_W-1] ? DATA_W'(-num_i) : DATA_W'(num_i);
  // upper bits of the shifted numerator; at or above den means q >= 2^32
  assign top = {{(DATA_W-FRAC_BITS){1'b0}}, mag[DATA_W-1 -: FRAC_BITS]};

  always_ff @(posedge clk_i) begin
    rem_q[0] <= top;
    low_q[0] <= {mag[DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    neg_q[0] <= num_i[DATA_W-1];
    ovf_q[0] <= top >= den_i;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DATA_W:0] trial;
    logic            ge;
    assign trial = {rem_q[k], low_q[k][DATA_W-1]};
    assign ge    = trial >= {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? DATA_W'(trial - {1'b0, den_q[k]}) : trial[DATA_W-1:0];
      low_q[k+1] <= {low_q[k][DATA_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][DATA_W-2:0], ge};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign q_end = quo_q[DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (!neg_q[DIV_STAGES]) begin
      quot_q <= (ovf_q[DIV_STAGES] || q_end[DATA_W-1]) ? 32'sh7FFF_FFFF : signed'(q_end);
    end else if (ovf_q[DIV_STAGES] || q_end > 32'h8000_0000) begin
      quot_q <= 32'sh8000_0000;
    end else begin
      quot_q <= signed'(DATA_W'(-q_end));
    end
  end

  assign quot_o = quot_q;

endmodule

// ----- rtl/core/mgnu_back.sv -----
// Back end: three divider lanes, gravity, walls and obstacle response.
// Depends on mgnu_pkg and mgnu_div.
`timescale 1ns / 1ps
module mgnu_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mgnu_pkg::item_t item_i,
  input  mgnu_pkg::cfg_t  cfg_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output mgnu_pkg::out_t  result_o
);
  import mgnu_pkg::*;

  logic  line_v_q [DIV_LAT];
  item_t line_q   [DIV_LAT];
  logic signed [DATA_W-1:0] quot [3];
  logic signed [DATA_W-1:0] ov   [3];
  logic signed [DATA_W-1:0] mom  [3];

  logic                     va_q, vb_q, vc_q;
  item_t                    sa_q, sb_q;
  logic signed [DATA_W-1:0] a_vel_q [3];
  logic signed [DATA_W-1:0] b_vel_q [3];
  logic signed [DATA_W:0]   b_rel_q [3];
  logic                     b_take_q;
  out_t                     res_q, res_d;
  logic signed [DATA_W-1:0] a_vel_d [3];
  logic signed [DATA_W:0]   b_rel_d [3];
  logic                     b_take_d;

  assign pop_o = valid_i;

  mgnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i(clk_i), .num_i(item_i.node.momentum_x), .den_i(item_i.node.node_mass),
    .quot_o(quot[0]));
  mgnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i(clk_i), .num_i(item_i.node.momentum_y), .den_i(item_i.node.node_mass),
    .quot_o(quot[1]));
  mgnu_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk_i(clk_i), .num_i(item_i.node.momentum_z), .den_i(item_i.node.node_mass),
    .quot_o(quot[2]));

  assign ov[0] = cfg_i.vel_x;
  assign ov[1] = '0;
  assign ov[2] = cfg_i.vel_z;

  // sideband travels alongside the divider lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) line_v_q[i] <= 1'b0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      line_v_q[0] <= valid_i;
      for (int i = 1; i < DIV_LAT; i++) line_v_q[i] <= line_v_q[i-1];
      va_q <= line_v_q[DIV_LAT-1];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q[0] <= item_i;
    for (int i = 1; i < DIV_LAT; i++) line_q[i] <= line_q[i-1];
  end

  // stage A: gravity and walls
  always_comb begin
    logic signed [33:0] gy;
    item_t s;
    s  = line_q[DIV_LAT-1];
    gy = 34'(quot[1]) - signed'({18'b0, cfg_i.gravity_step});
    for (int a = 0; a < 3; a++) begin
      a_vel_d[a] = (a == 1) ? sat34(gy) : quot[a];
      if (s.wall_lo[a] && a_vel_d[a] < 0) a_vel_d[a] = '0;
      if (s.wall_hi[a] && a_vel_d[a] > 0) a_vel_d[a] = '0;
    end
  end

  // stage B: velocity relative to the obstacle, decide response
  always_comb begin
    logic signed [DATA_W:0] rn;
    for (int a = 0; a < 3; a++) begin
      b_rel_d[a] = 33'(a_vel_q[a]) - 33'(ov[a]);
    end
    rn = b_rel_d[sa_q.axis];
    b_take_d = (sa_q.node.node_mass != '0) && sa_q.in_obst &&
               (sa_q.positive ? (rn < 0) : (rn > 0));
  end

  assign mom[0] = sb_q.node.momentum_x;
  assign mom[1] = sb_q.node.momentum_y;
  assign mom[2] = sb_q.node.momentum_z;

  // stage C: apply response, pass empty nodes through
  always_comb begin
    logic signed [DATA_W-1:0] v [3];
    logic                     act;
    act = sb_q.node.node_mass != '0;
    for (int a = 0; a < 3; a++) begin
      if (!act) begin
        v[a] = mom[a];
      end else if (b_take_q) begin
        v[a] = (axis_e'(2'(a)) == sb_q.axis) ? ov[a] :
               sat34(34'(b_rel_q[a] >>> 1) + 34'(ov[a]));
      end else begin
        v[a] = b_vel_q[a];
      end
    end
    res_d.velocity_x   = v[0];
    res_d.velocity_y   = v[1];
    res_d.velocity_z   = v[2];
    res_d.node_active  = act;
    res_d.hit_obstacle = b_take_q;
  end

  always_ff @(posedge clk_i) begin
    sa_q     <= line_q[DIV_LAT-1];
    sb_q     <= sa_q;
    a_vel_q  <= a_vel_d;
    b_vel_q  <= a_vel_q;
    b_rel_q  <= b_rel_d;
    b_take_q <= b_take_d;
    res_q    <= res_d;
  end

  assign result_valid_o = vc_q;
  assign result_o       = res_q;

  a_hit_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && res_q.hit_obstacle |-> res_q.node_active)
    else $error("obstacle hit on empty node");
  a_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> $past(va_q, 2))
    else $error("result without stage A");
  a_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> $past(valid_i, DIV_LAT + 1))
    else $error("stage A without a popped request");

endmodule

// ----- rtl/core/mpm_grid_node_update_top.sv -----
// Top level of the grid node update: config registers, front, queue, back.
// Depends on mgnu_pkg, mgnu_front, mgnu_fifo, mgnu_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------
//  request   | start / busy          | item_i   (mgnu_pkg::in_t)
//  result    | result_valid_o strobe | result_o (mgnu_pkg::out_t)
//  config    | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while busy stays low. A request accepted
// at an edge passes the front register, the queue, the 34-stage divider
// lanes (one quotient bit per stage), then three post stages, to its result.
// Reset clears the pipeline valids and queue pointers and loads the config
// registers with their defaults.
// The back end never stalls; with QUEUE_DEPTH >= 2 the queue drains and busy stays low.
`timescale 1ns / 1ps
module mpm_grid_node_update_top #(
  parameter int GRID_SIZE   = 64,
  parameter int WALL_CELLS  = 2,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  mgnu_pkg::in_t                        item_i,
  input  logic                                 cfg_we_i,
  input  logic [mgnu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mgnu_pkg::DATA_W-1:0]          cfg_wdata_i,
  output logic                                 result_valid_o,
  output mgnu_pkg::out_t                       result_o
);
  import mgnu_pkg::*;

  cfg_t  cfg_q;
  logic  push, q_ready, q_valid, pop;
  item_t f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_step <= 16'd128;
      cfg_q.center_x     <= 22'd2936013;
      cfg_q.center_y     <= 22'd419430;
      cfg_q.center_z     <= 22'd2097152;
      cfg_q.vel_x        <= 32'sd0;
      cfg_q.vel_z        <= 32'sd39322;
      cfg_q.half_xz      <= 22'd209715;
      cfg_q.half_y       <= 22'd419430;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY: cfg_q.gravity_step <= cfg_wdata_i[GS_W-1:0];
        CFG_CX:      cfg_q.center_x     <= cfg_wdata_i[POS_W-1:0];
        CFG_CY:      cfg_q.center_y     <= cfg_wdata_i[POS_W-1:0];
        CFG_CZ:      cfg_q.center_z     <= cfg_wdata_i[POS_W-1:0];
        CFG_VX:      cfg_q.vel_x        <= signed'(cfg_wdata_i);
        CFG_VZ:      cfg_q.vel_z        <= signed'(cfg_wdata_i);
        CFG_HXZ:     cfg_q.half_xz      <= cfg_wdata_i[POS_W-1:0];
        CFG_HY:      cfg_q.half_y       <= cfg_wdata_i[POS_W-1:0];
        default:     cfg_q              <= cfg_q;
      endcase
    end
  end

  mgnu_front #(
    .GRID_SIZE(GRID_SIZE), .WALL_CELLS(WALL_CELLS), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .cfg_i(cfg_q), .ready_i(q_ready), .busy(busy), .push_o(push),
    .item_o(f_item));

  mgnu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(f_item),
    .ready_o(q_ready), .pop_i(pop), .valid_o(q_valid), .data_o(q_item));

  mgnu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .item_i(q_item),
    .cfg_i(cfg_q), .pop_o(pop), .result_valid_o(result_valid_o),
    .result_o(result_o));

endmodule
